// ===== hdl/arst_pkg.sv =====
// Shared types and constants for the address range set table.
// Holds request/response structs, entry layout and control encodings.
// No dependencies.
package arst_pkg;

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } arst_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_BAD_INDEX = 2'd3
    } arst_status_t;

    // What every cell of the row does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_ROTATE = 3'd1,
        CELL_OPEN   = 3'd2,
        CELL_CLOSE  = 3'd3,
        CELL_WRITE  = 3'd4
    } arst_cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SCAN   = 3'd1,
        ST_APPLY  = 3'd2,
        ST_MERGE  = 3'd3,
        ST_FINISH = 3'd4
    } arst_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] beg;
        logic [ADDR_W-1:0] fin;
    } arst_entry_t;

    typedef struct packed {
        arst_mode_t         mode;
        logic [ADDR_W-1:0]  range_low;
        logic [ADDR_W-1:0]  range_high;
        logic [ADDR_W-1:0]  probe_address;
        logic [INDEX_W-1:0] entry_index;
    } arst_req_t;

    typedef struct packed {
        arst_status_t       status;
        logic [ADDR_W-1:0]  entry_begin;
        logic [ADDR_W-1:0]  entry_end;
        logic [COUNT_W-1:0] entry_count;
    } arst_rsp_t;

endpackage

// ===== hdl/arst_cell.sv =====
// One cell of the range table row: holds a single entry.
// Takes its neighbor's entry on rotate, open and close; depends on arst_pkg.
module arst_cell #(
    parameter int TABLE_DEPTH = 256,
    parameter int CELL_INDEX  = 0
) (
    input  logic                  clk,
    input  arst_pkg::arst_cell_op_t op,
    input  logic [$clog2(TABLE_DEPTH)-1:0] pos,
    input  arst_pkg::arst_entry_t wr_entry,
    input  arst_pkg::arst_entry_t prev_entry,
    input  arst_pkg::arst_entry_t next_entry,
    output arst_pkg::arst_entry_t entry
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_INDEX);

    arst_pkg::arst_entry_t entry_reg;
    arst_pkg::arst_entry_t entry_next;

    // Next entry per row operation
    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            arst_pkg::CELL_HOLD:   entry_next = entry_reg;
            arst_pkg::CELL_ROTATE: entry_next = next_entry;
            arst_pkg::CELL_OPEN:
            begin
                if (MY_POS > pos)
                    entry_next = prev_entry;
                else if (MY_POS == pos)
                    entry_next = wr_entry;
            end
            arst_pkg::CELL_CLOSE:
            begin
                if (MY_POS >= pos)
                    entry_next = next_entry;
            end
            arst_pkg::CELL_WRITE:
            begin
                if (MY_POS == pos)
                    entry_next = wr_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/address_range_set_table.sv =====
// Top level of the address range set table: controller plus the row of cells.
// Depends on arst_pkg and arst_cell.
//
// Keeps up to TABLE_DEPTH sorted, disjoint, inclusive 32-bit ranges in a ring
// of cells, entry i in cell i. One request is handled at a time. Every request
// except an insert into a full table rotates the ring once so that each entry
// passes the head cell, where a single compare unit finds the overlap, the
// containing range or the indexed entry; then an insert or delete shifts the
// row in parallel to open or close a slot, or widens the first overlapped entry
// in place. An insert that merges m+1 ranges then closes the m other slots one
// at a time. A new request is taken once the previous one has moved into the
// response register, even while that response still waits.
module address_range_set_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  arst_pkg::arst_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output arst_pkg::arst_rsp_t rsp_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > arst_pkg::INDEX_W) ? CNT_W : arst_pkg::INDEX_W;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    // Row of cells
    arst_pkg::arst_entry_t   cell_q [TABLE_DEPTH];
    arst_pkg::arst_cell_op_t cell_op;
    logic [IDX_W-1:0]        cell_pos;
    arst_pkg::arst_entry_t   cell_wr;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        arst_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .wr_entry   (cell_wr),
            .prev_entry (cell_q[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
            .next_entry (cell_q[(g + 1) % TABLE_DEPTH]),
            .entry      (cell_q[g])
        );
    end

    // Control registers
    arst_pkg::arst_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Datapath registers
    arst_pkg::arst_mode_t      mode_reg, mode_next;
    logic [arst_pkg::ADDR_W-1:0]  kb_reg, kb_next;
    logic [arst_pkg::ADDR_W-1:0]  ke_reg, ke_next;
    logic [arst_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0]          scan_reg, scan_next;
    logic                      hit_any_reg, hit_any_next;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic [arst_pkg::ADDR_W-1:0]  hit_beg_reg, hit_beg_next;
    logic [arst_pkg::ADDR_W-1:0]  hit_end_reg, hit_end_next;
    logic [arst_pkg::ADDR_W-1:0]  last_end_reg, last_end_next;
    logic [IDX_W-1:0]          p_reg, p_next;
    logic                      p_found_reg, p_found_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]          merge_cnt_reg, merge_cnt_next;
    arst_pkg::arst_status_t    res_status_reg, res_status_next;
    logic [arst_pkg::ADDR_W-1:0]  res_beg_reg, res_beg_next;
    logic [arst_pkg::ADDR_W-1:0]  res_end_reg, res_end_next;
    arst_pkg::arst_rsp_t       rsp_reg, rsp_next;

    // Head compare terms
    arst_pkg::arst_entry_t head;
    logic                  t_valid;
    logic                  ov;
    logic                  idx_match;
    logic                  hit;
    logic                  above;
    logic [arst_pkg::ADDR_W-1:0] merged_beg;
    logic [arst_pkg::ADDR_W-1:0] merged_end;
    logic [IDX_W-1:0]      merge_span;

    assign head      = cell_q[0];
    assign t_valid   = CNT_W'(scan_reg) < count_reg;
    assign ov        = (head.beg <= ke_reg) && (head.fin >= kb_reg);
    assign idx_match = CMP_W'(idx_reg) == CMP_W'(scan_reg);
    assign hit       = t_valid && ((mode_reg == arst_pkg::MODE_READ) ? idx_match : ov);
    assign above     = t_valid && (head.beg > kb_reg);

    assign merged_beg = (kb_reg < hit_beg_reg) ? kb_reg : hit_beg_reg;
    assign merged_end = (ke_reg > last_end_reg) ? ke_reg : last_end_reg;
    assign merge_span = hi_reg - lo_reg;

    assign req_ready = (state_reg == arst_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Next state, row control and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        mode_next       = mode_reg;
        kb_next         = kb_reg;
        ke_next         = ke_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        hit_any_next    = hit_any_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hit_beg_next    = hit_beg_reg;
        hit_end_next    = hit_end_reg;
        last_end_next   = last_end_reg;
        p_next          = p_reg;
        p_found_next    = p_found_reg;
        pos_next        = pos_reg;
        merge_cnt_next  = merge_cnt_reg;
        res_status_next = res_status_reg;
        res_beg_next    = res_beg_reg;
        res_end_next    = res_end_reg;
        rsp_next        = rsp_reg;
        cell_op         = arst_pkg::CELL_HOLD;
        cell_pos        = pos_reg;
        cell_wr         = '{beg: kb_reg, fin: ke_reg};

        case (state_reg)
            arst_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next    = req_data.mode;
                    idx_next     = req_data.entry_index;
                    scan_next    = '0;
                    hit_any_next = 1'b0;
                    p_found_next = 1'b0;
                    p_next       = IDX_W'(count_reg);
                    if (req_data.mode == arst_pkg::MODE_INSERT)
                    begin
                        // reversed bounds are swapped
                        if (req_data.range_low > req_data.range_high)
                        begin
                            kb_next = req_data.range_high;
                            ke_next = req_data.range_low;
                        end
                        else
                        begin
                            kb_next = req_data.range_low;
                            ke_next = req_data.range_high;
                        end
                    end
                    else
                    begin
                        kb_next = req_data.probe_address;
                        ke_next = req_data.probe_address;
                    end
                    if (req_data.mode == arst_pkg::MODE_INSERT && count_reg == FULL_CNT)
                    begin
                        res_status_next = arst_pkg::STATUS_FULL;
                        res_beg_next    = '0;
                        res_end_next    = '0;
                        state_next      = arst_pkg::ST_FINISH;
                    end
                    else
                        state_next = arst_pkg::ST_SCAN;
                end
            end

            arst_pkg::ST_SCAN:
            begin
                // one full ring turn; entry scan_reg sits in the head cell
                cell_op = arst_pkg::CELL_ROTATE;
                if (hit && !hit_any_reg)
                begin
                    lo_next      = scan_reg;
                    hit_beg_next = head.beg;
                    hit_end_next = head.fin;
                end
                if (hit)
                begin
                    hi_next       = scan_reg;
                    last_end_next = head.fin;
                    hit_any_next  = 1'b1;
                end
                if (above && !p_found_reg)
                begin
                    p_next       = scan_reg;
                    p_found_next = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_POS)
                    state_next = arst_pkg::ST_APPLY;
            end

            arst_pkg::ST_APPLY:
            begin
                state_next = arst_pkg::ST_FINISH;
                case (mode_reg)
                    arst_pkg::MODE_INSERT:
                    begin
                        res_status_next = arst_pkg::STATUS_OK;
                        if (!hit_any_reg)
                        begin
                            // no overlap: open a slot
                            cell_op      = arst_pkg::CELL_OPEN;
                            cell_pos     = p_reg;
                            cell_wr      = '{beg: kb_reg, fin: ke_reg};
                            count_next   = count_reg + 1'b1;
                            res_beg_next = kb_reg;
                            res_end_next = ke_reg;
                        end
                        else
                        begin
                            // widen first overlapped entry, then drop the rest
                            cell_op        = arst_pkg::CELL_WRITE;
                            cell_pos       = lo_reg;
                            cell_wr        = '{beg: merged_beg, fin: merged_end};
                            count_next     = count_reg - CNT_W'(merge_span);
                            pos_next       = lo_reg + 1'b1;
                            merge_cnt_next = merge_span;
                            res_beg_next   = merged_beg;
                            res_end_next   = merged_end;
                            if (merge_span != '0)
                                state_next = arst_pkg::ST_MERGE;
                        end
                    end
                    arst_pkg::MODE_LOOKUP, arst_pkg::MODE_DELETE:
                    begin
                        if (hit_any_reg)
                        begin
                            res_status_next = arst_pkg::STATUS_OK;
                            res_beg_next    = hit_beg_reg;
                            res_end_next    = hit_end_reg;
                            if (mode_reg == arst_pkg::MODE_DELETE)
                            begin
                                cell_op    = arst_pkg::CELL_CLOSE;
                                cell_pos   = lo_reg;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = arst_pkg::STATUS_NOT_FOUND;
                            res_beg_next    = '0;
                            res_end_next    = '0;
                        end
                    end
                    arst_pkg::MODE_READ:
                    begin
                        if (hit_any_reg)
                        begin
                            res_status_next = arst_pkg::STATUS_OK;
                            res_beg_next    = hit_beg_reg;
                            res_end_next    = hit_end_reg;
                        end
                        else
                        begin
                            res_status_next = arst_pkg::STATUS_BAD_INDEX;
                            res_beg_next    = '0;
                            res_end_next    = '0;
                        end
                    end
                    default: state_next = arst_pkg::ST_FINISH;
                endcase
            end

            arst_pkg::ST_MERGE:
            begin
                // close one slot per cycle after the merged entry
                cell_op        = arst_pkg::CELL_CLOSE;
                cell_pos       = pos_reg;
                merge_cnt_next = merge_cnt_reg - 1'b1;
                if (merge_cnt_reg == IDX_W'(1))
                    state_next = arst_pkg::ST_FINISH;
            end

            arst_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status:      res_status_reg,
                                       entry_begin: res_beg_reg,
                                       entry_end:   res_end_reg,
                                       entry_count: arst_pkg::COUNT_W'(count_reg)};
                    state_next     = arst_pkg::ST_IDLE;
                end
            end

            default: state_next = arst_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arst_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        kb_reg         <= kb_next;
        ke_reg         <= ke_next;
        idx_reg        <= idx_next;
        scan_reg       <= scan_next;
        hit_any_reg    <= hit_any_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hit_beg_reg    <= hit_beg_next;
        hit_end_reg    <= hit_end_next;
        last_end_reg   <= last_end_next;
        p_reg          <= p_next;
        p_found_reg    <= p_found_next;
        pos_reg        <= pos_next;
        merge_cnt_reg  <= merge_cnt_next;
        res_status_reg <= res_status_next;
        res_beg_reg    <= res_beg_next;
        res_end_reg    <= res_end_next;
        rsp_reg        <= rsp_next;
    end

`ifndef SYNTHESIS
    // Table never holds more than it has cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above table depth");

    // Entry count moves only when an operation is applied
    a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == arst_pkg::ST_APPLY))
        else $error("entry count changed outside apply");

    // Overlap run is ordered when applied
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arst_pkg::ST_APPLY && hit_any_reg) |-> (lo_reg <= hi_reg))
        else $error("first hit after last hit");

    // Merge loop always has work left
    a_merge_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arst_pkg::ST_MERGE) |-> (merge_cnt_reg != '0))
        else $error("merge loop with nothing to remove");
`endif

endmodule
